// ----- sv/atc_pkg.sv -----
// ============================================================================
// AFSK tone correlator package
// Shared widths, output limits, tone frequencies and the controller's
// state and command types.
// ============================================================================
`default_nettype none

package atc_pkg;

	// Width of one audio sample and of one reference table entry.
	localparam int SampleW = 16;
	localparam int RefW    = 16;

	// Width and limits of one correlation result.
	localparam int SumW   = 21;
	localparam int SumMax = 1048575;
	localparam int SumMin = -1048576;

	// Right shift that rescales a Q15 product sum.
	localparam int SumShift = 15;

	// Mark and space tone frequencies in hertz.
	localparam int unsigned MarkFreq  = 1200;
	localparam int unsigned SpaceFreq = 2200;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_EMIT
	} atc_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} atc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_tap;
	} atc_status_t;

endpackage

`default_nettype wire

// ----- sv/atc_sample_if.sv -----
// ============================================================================
// AFSK tone correlator sample channel
// Valid/ready channel that carries one signed audio sample per item.
// ============================================================================
`default_nettype none

interface atc_sample_if;
	logic                               valid;
	logic                               ready;
	logic signed [atc_pkg::SampleW-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- sv/atc_result_if.sv -----
// ============================================================================
// AFSK tone correlator result channel
// Valid/ready channel that carries the four correlation sums of one item.
// ============================================================================
`default_nettype none

interface atc_result_if;
	logic                            valid;
	logic                            ready;
	logic signed [atc_pkg::SumW-1:0] mark_cos_sum;
	logic signed [atc_pkg::SumW-1:0] mark_sin_sum;
	logic signed [atc_pkg::SumW-1:0] space_cos_sum;
	logic signed [atc_pkg::SumW-1:0] space_sin_sum;

	modport source(output valid, output mark_cos_sum, output mark_sin_sum,
		output space_cos_sum, output space_sin_sum, input ready);
	modport sink(input valid, input mark_cos_sum, input mark_sin_sum,
		input space_cos_sum, input space_sin_sum, output ready);
endinterface

`default_nettype wire

// ----- sv/afsk_tone_correlator_unit.sv -----
// ============================================================================
// AFSK tone correlator unit
// Correlates a one-bit window of audio samples against mark and space
// cosine and sine references and returns four saturated sums per sample.
// ============================================================================
//
//  Channel   Direction  Payload                                  Per item
//  samples   in         sample (16b signed)                      one sample
//  results   out        mark_cos/sin_sum, space_cos/sin_sum      four 21b sums
//                       (21b signed each)
//
// An item runs in steps: the cycle in which it is accepted writes the sample,
// one cycle per window tap runs the four-lane multiply-accumulate, and the
// emit state then loads the output register once that register is free.
// A new item is accepted only while idle, after the last one has emitted.
// A stalled sink holds the output register; the next item still runs, then
// waits for the register to empty. Reset clears the window and write pointer.
// ============================================================================
`default_nettype none

module afsk_tone_correlator_unit #(
	parameter int WINDOW   = 8,
	parameter int BIT_RATE = 1200
) (
	input  wire           clk,
	input  wire           arst_n,
	atc_sample_if.sink    samples,
	atc_result_if.source  results
);

	atc_pkg::atc_cmd_t    cmd;
	atc_pkg::atc_status_t status;

	atc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	atc_datapath #(
		.WINDOW   (WINDOW),
		.BIT_RATE (BIT_RATE)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample        (samples.sample),
		.cmd           (cmd),
		.status        (status),
		.mark_cos_sum  (results.mark_cos_sum),
		.mark_sin_sum  (results.mark_sin_sum),
		.space_cos_sum (results.space_cos_sum),
		.space_sin_sum (results.space_sin_sum)
	);

endmodule

`default_nettype wire

// ----- sv/atc_ctrl.sv -----
// ============================================================================
// AFSK tone correlator controller
// Sequences one item: sample write, one window tap per cycle, then the
// hand-off of the finished sums into the output register.
// ============================================================================
`default_nettype none

module atc_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire                  out_ready,
	input  atc_pkg::atc_status_t status,
	output atc_pkg::atc_cmd_t    cmd
);

	atc_pkg::atc_state_t state_q;
	atc_pkg::atc_state_t state_next;
	logic                out_valid_q;

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= atc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			atc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = atc_pkg::ST_RUN;
				end
			end
			atc_pkg::ST_RUN: begin
				cmd.step = 1'b1;
				if (status.last_tap) begin
					state_next = atc_pkg::ST_EMIT;
				end
			end
			atc_pkg::ST_EMIT: begin
				// The output register is free, or is being emptied this cycle.
				if (!out_valid_q || out_ready) begin
					cmd.emit   = 1'b1;
					state_next = atc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = atc_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- sv/atc_datapath.sv -----
// ============================================================================
// AFSK tone correlator datapath
// Sample window, reference tables, four multiply-accumulate lanes and the
// saturating output register.
// ============================================================================
`default_nettype none

module atc_datapath #(
	parameter int WINDOW   = 8,
	parameter int BIT_RATE = 1200
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire signed [atc_pkg::SampleW-1:0]  sample,
	input  atc_pkg::atc_cmd_t                  cmd,
	output atc_pkg::atc_status_t               status,
	output logic signed [atc_pkg::SumW-1:0]    mark_cos_sum,
	output logic signed [atc_pkg::SumW-1:0]    mark_sin_sum,
	output logic signed [atc_pkg::SumW-1:0]    space_cos_sum,
	output logic signed [atc_pkg::SumW-1:0]    space_sin_sum
);

	localparam int PtrW  = $clog2(WINDOW);
	localparam int ProdW = atc_pkg::SampleW + atc_pkg::RefW;
	localparam int AccW  = ProdW + PtrW;
	localparam int ShW   = AccW - atc_pkg::SumShift;
	localparam int CmpW  = (ShW > atc_pkg::SumW) ? ShW : atc_pkg::SumW;

	localparam logic [PtrW-1:0] LastIdx = PtrW'(WINDOW - 1);

	localparam logic signed [CmpW-1:0] SatHi = CmpW'(atc_pkg::SumMax);
	localparam logic signed [CmpW-1:0] SatLo = CmpW'(atc_pkg::SumMin);

	// Phase constants for the reference tables.
	localparam longint unsigned Den       = longint'(WINDOW) * longint'(BIT_RATE);
	localparam longint unsigned HalfPiQ30 = 64'd1686629713;
	localparam longint unsigned OneQ30    = 64'd1 << 30;

	// Rounds a Q30 magnitude to Q15, clamped to [0, 32767].
	function automatic longint unsigned q30_to_q15(input longint v);
		longint unsigned m;
		if (v < 0) begin
			m = 0;
		end else begin
			m = (longint'(v) + 64'd16384) >> 15;
		end
		if (m > 64'd32767) begin
			m = 64'd32767;
		end
		return m;
	endfunction

	// One Q1.15 reference entry, evaluated at elaboration with truncated
	// Q30 Taylor series of seven terms for sine and cosine.
	function automatic logic signed [atc_pkg::RefW-1:0] ref_entry(
		input int unsigned idx,
		input int unsigned freq,
		input bit          want_cos
	);
		longint unsigned p;
		longint unsigned t;
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned quad;
		longint          ss;
		longint          cc;
		longint          sm;
		longint          cm;
		longint          sv;
		longint          cv;
		p    = (longint'(idx) * longint'(freq)) % Den;
		t    = (p << 32) / Den;
		quad = (t >> 30) & 64'd3;
		r    = t & (OneQ30 - 64'd1);
		x    = (r * HalfPiQ30) >> 30;
		x2   = (x * x) >> 30;

		// Sine series.
		ss   = longint'(x);
		term = ((x * x2) >> 30) / 6;
		ss   = ss - longint'(term);
		term = ((term * x2) >> 30) / 20;
		ss   = ss + longint'(term);
		term = ((term * x2) >> 30) / 42;
		ss   = ss - longint'(term);
		term = ((term * x2) >> 30) / 72;
		ss   = ss + longint'(term);
		term = ((term * x2) >> 30) / 110;
		ss   = ss - longint'(term);
		term = ((term * x2) >> 30) / 156;
		ss   = ss + longint'(term);

		// Cosine series.
		cc   = longint'(OneQ30);
		term = ((OneQ30 * x2) >> 30) / 2;
		cc   = cc - longint'(term);
		term = ((term * x2) >> 30) / 12;
		cc   = cc + longint'(term);
		term = ((term * x2) >> 30) / 30;
		cc   = cc - longint'(term);
		term = ((term * x2) >> 30) / 56;
		cc   = cc + longint'(term);
		term = ((term * x2) >> 30) / 90;
		cc   = cc - longint'(term);
		term = ((term * x2) >> 30) / 132;
		cc   = cc + longint'(term);

		sm = longint'(q30_to_q15(ss));
		cm = longint'(q30_to_q15(cc));
		case (quad)
			64'd0: begin
				sv = sm;
				cv = cm;
			end
			64'd1: begin
				sv = cm;
				cv = -sm;
			end
			64'd2: begin
				sv = -sm;
				cv = -cm;
			end
			default: begin
				sv = -cm;
				cv = sm;
			end
		endcase
		return want_cos ? atc_pkg::RefW'(cv) : atc_pkg::RefW'(sv);
	endfunction

	// Saturates a shifted sum to the output range.
	function automatic logic signed [atc_pkg::SumW-1:0] saturate(
		input logic signed [AccW-1:0] acc
	);
		logic signed [ShW-1:0]  sh;
		logic signed [CmpW-1:0] wide;
		sh   = ShW'(acc >>> atc_pkg::SumShift);
		wide = CmpW'(sh);
		if (wide > SatHi) begin
			wide = SatHi;
		end else if (wide < SatLo) begin
			wide = SatLo;
		end
		return atc_pkg::SumW'(wide);
	endfunction

	// Reference tables, one constant entry per window tap.
	logic signed [atc_pkg::RefW-1:0] mark_cos_rom  [WINDOW];
	logic signed [atc_pkg::RefW-1:0] mark_sin_rom  [WINDOW];
	logic signed [atc_pkg::RefW-1:0] space_cos_rom [WINDOW];
	logic signed [atc_pkg::RefW-1:0] space_sin_rom [WINDOW];

	for (genvar g = 0; g < WINDOW; g++) begin : g_rom
		localparam logic signed [atc_pkg::RefW-1:0] Mc =
			ref_entry(g, atc_pkg::MarkFreq, 1'b1);
		localparam logic signed [atc_pkg::RefW-1:0] Ms =
			ref_entry(g, atc_pkg::MarkFreq, 1'b0);
		localparam logic signed [atc_pkg::RefW-1:0] Sc =
			ref_entry(g, atc_pkg::SpaceFreq, 1'b1);
		localparam logic signed [atc_pkg::RefW-1:0] Ss =
			ref_entry(g, atc_pkg::SpaceFreq, 1'b0);
		assign mark_cos_rom[g]  = Mc;
		assign mark_sin_rom[g]  = Ms;
		assign space_cos_rom[g] = Sc;
		assign space_sin_rom[g] = Ss;
	end

	logic signed [atc_pkg::SampleW-1:0] window_q [WINDOW];
	logic [PtrW-1:0]                    wr_ptr_q;
	logic [PtrW-1:0]                    rd_ptr_q;
	logic [PtrW-1:0]                    tap_q;
	logic [PtrW-1:0]                    wr_ptr_inc;
	logic [PtrW-1:0]                    rd_ptr_inc;
	logic signed [AccW-1:0]             mc_acc_q;
	logic signed [AccW-1:0]             ms_acc_q;
	logic signed [AccW-1:0]             sc_acc_q;
	logic signed [AccW-1:0]             ss_acc_q;
	logic signed [atc_pkg::SampleW-1:0] tap_sample;
	logic signed [ProdW-1:0]            mc_prod;
	logic signed [ProdW-1:0]            ms_prod;
	logic signed [ProdW-1:0]            sc_prod;
	logic signed [ProdW-1:0]            ss_prod;

	// Circular pointer increments.
	assign wr_ptr_inc = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
	assign rd_ptr_inc = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;

	// Sample window and write pointer, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				window_q[i] <= '0;
			end
			wr_ptr_q <= '0;
		end else if (cmd.load) begin
			window_q[wr_ptr_q] <= sample;
			wr_ptr_q           <= wr_ptr_inc;
		end
	end

	// Read pointer and tap counter; the read starts at the oldest sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			tap_q    <= '0;
		end else if (cmd.load) begin
			rd_ptr_q <= wr_ptr_inc;
			tap_q    <= '0;
		end else if (cmd.step) begin
			rd_ptr_q <= rd_ptr_inc;
			tap_q    <= tap_q + 1'b1;
		end
	end

	assign status.last_tap = (tap_q == LastIdx);

	// One tap of all four correlations.
	assign tap_sample = window_q[rd_ptr_q];
	assign mc_prod    = ProdW'(tap_sample) * ProdW'(mark_cos_rom[tap_q]);
	assign ms_prod    = ProdW'(tap_sample) * ProdW'(mark_sin_rom[tap_q]);
	assign sc_prod    = ProdW'(tap_sample) * ProdW'(space_cos_rom[tap_q]);
	assign ss_prod    = ProdW'(tap_sample) * ProdW'(space_sin_rom[tap_q]);

	// Accumulators.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mc_acc_q <= '0;
			ms_acc_q <= '0;
			sc_acc_q <= '0;
			ss_acc_q <= '0;
		end else if (cmd.step) begin
			mc_acc_q <= mc_acc_q + AccW'(mc_prod);
			ms_acc_q <= ms_acc_q + AccW'(ms_prod);
			sc_acc_q <= sc_acc_q + AccW'(sc_prod);
			ss_acc_q <= ss_acc_q + AccW'(ss_prod);
		end
	end

	// Output register, loaded with the scaled and saturated sums.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			mark_cos_sum  <= saturate(mc_acc_q);
			mark_sin_sum  <= saturate(ms_acc_q);
			space_cos_sum <= saturate(sc_acc_q);
			space_sin_sum <= saturate(ss_acc_q);
		end
	end

endmodule

`default_nettype wire

// ----- verif/atc_correlation_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// AFSK tone correlator result checker
// Watches the sample and result channels of the correlator. For every
// accepted sample it predicts the four mark and space correlation sums from
// its own copy of the sample window and its own reference tables. It then
// compares each accepted result item with the oldest prediction, and counts
// every mismatch and every result item that arrives with no prediction left.
// ============================================================================

module atc_correlation_checker #(
	parameter int WINDOW   = 8,
	parameter int BIT_RATE = 1200
) (
	input  wire         clk,
	input  wire         arst_n,
	atc_sample_if       samples,
	atc_result_if       results,
	output int unsigned mismatch_count,
	output int unsigned pending_count
);

	// Pi/2 in Q30 and one in Q30, as used to build the reference tables.
	localparam longint unsigned HalfPiQ30 = 64'd1686629713;
	localparam longint unsigned OneQ30    = 64'd1 << 30;

	typedef struct packed {
		logic signed [atc_pkg::SumW-1:0] mark_cos;
		logic signed [atc_pkg::SumW-1:0] mark_sin;
		logic signed [atc_pkg::SumW-1:0] space_cos;
		logic signed [atc_pkg::SumW-1:0] space_sin;
	} tone_sums_t;

	// Q1.15 references, one entry per window position.
	int mark_cos_tbl  [WINDOW];
	int mark_sin_tbl  [WINDOW];
	int space_cos_tbl [WINDOW];
	int space_sin_tbl [WINDOW];

	// Model of the sample window and its write position.
	logic signed [atc_pkg::SampleW-1:0] window_model [WINDOW];
	int unsigned                        write_pos;

	// Sums predicted for accepted samples, oldest first.
	tone_sums_t expected_sums [$];

	// Rounds a Q30 magnitude to Q15, clamped to the range of one entry.
	function automatic int q15_magnitude(input longint value);
		longint rounded;
		if (value < 0) begin
			value = 0;
		end
		rounded = (value + 16384) >>> 15;
		if (rounded > 32767) begin
			rounded = 32767;
		end
		return int'(rounded);
	endfunction

	// Cosine and sine of the angle phase / period turns, from truncated
	// Taylor series evaluated within one quadrant.
	function automatic void tone_point(input int unsigned phase, input int unsigned period,
			output int cos_q15, output int sin_q15);
		longint unsigned turn;
		longint unsigned rem;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sin_q30;
		longint          cos_q30;
		int unsigned     quadrant;
		int              sin_mag;
		int              cos_mag;
		int              k;
		turn = phase;
		turn = (turn << 32) / period;
		quadrant = int'((turn >> 30) & 64'd3);
		rem = turn & (OneQ30 - 1);
		x = (rem * HalfPiQ30) >> 30;
		x2 = (x * x) >> 30;
		sin_q30 = 0;
		term = x;
		for (k = 1; k <= 7; k++) begin
			if (k % 2 == 1) begin
				sin_q30 += longint'(term);
			end else begin
				sin_q30 -= longint'(term);
			end
			term = ((term * x2) >> 30) / longint'(2 * k * (2 * k + 1));
		end
		cos_q30 = 0;
		term = OneQ30;
		for (k = 1; k <= 7; k++) begin
			if (k % 2 == 1) begin
				cos_q30 += longint'(term);
			end else begin
				cos_q30 -= longint'(term);
			end
			term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
		end
		sin_mag = q15_magnitude(sin_q30);
		cos_mag = q15_magnitude(cos_q30);
		case (quadrant)
			0: begin
				sin_q15 = sin_mag;
				cos_q15 = cos_mag;
			end
			1: begin
				sin_q15 = cos_mag;
				cos_q15 = -sin_mag;
			end
			2: begin
				sin_q15 = -sin_mag;
				cos_q15 = -cos_mag;
			end
			default: begin
				sin_q15 = -cos_mag;
				cos_q15 = sin_mag;
			end
		endcase
	endfunction

	// Rescales a product sum by 2^-15, rounding down, and saturates it.
	function automatic logic signed [atc_pkg::SumW-1:0] scale_and_clip(
			input longint acc);
		longint scaled;
		scaled = acc >>> atc_pkg::SumShift;
		if (scaled > atc_pkg::SumMax) begin
			scaled = atc_pkg::SumMax;
		end
		if (scaled < atc_pkg::SumMin) begin
			scaled = atc_pkg::SumMin;
		end
		return scaled[atc_pkg::SumW-1:0];
	endfunction

	// Writes a sample into the window and correlates the whole window,
	// oldest sample first, against the four references.
	function automatic tone_sums_t correlate_window(
			input logic signed [atc_pkg::SampleW-1:0] value);
		longint     acc_mc;
		longint     acc_ms;
		longint     acc_sc;
		longint     acc_ss;
		longint     tap;
		int         i;
		tone_sums_t sums;
		window_model[write_pos] = value;
		write_pos = (write_pos + 1) % WINDOW;
		acc_mc = 0;
		acc_ms = 0;
		acc_sc = 0;
		acc_ss = 0;
		for (i = 0; i < WINDOW; i++) begin
			tap = longint'(window_model[(write_pos + i) % WINDOW]);
			acc_mc += tap * mark_cos_tbl[i];
			acc_ms += tap * mark_sin_tbl[i];
			acc_sc += tap * space_cos_tbl[i];
			acc_ss += tap * space_sin_tbl[i];
		end
		sums.mark_cos  = scale_and_clip(acc_mc);
		sums.mark_sin  = scale_and_clip(acc_ms);
		sums.space_cos = scale_and_clip(acc_sc);
		sums.space_sin = scale_and_clip(acc_ss);
		return sums;
	endfunction

	// Compares one field and counts a mismatch.
	task automatic check_field(input string name,
			input logic signed [atc_pkg::SumW-1:0] expected,
			input logic signed [atc_pkg::SumW-1:0] actual);
		if (actual !== expected) begin
			$error("%s: expected %0d, actual %0d", name, expected, actual);
			mismatch_count++;
		end
	endtask

	// Reference tables are fixed for the run.
	initial begin
		int unsigned period;
		period = WINDOW * BIT_RATE;
		for (int i = 0; i < WINDOW; i++) begin
			tone_point((i * atc_pkg::MarkFreq) % period, period,
				mark_cos_tbl[i], mark_sin_tbl[i]);
			tone_point((i * atc_pkg::SpaceFreq) % period, period,
				space_cos_tbl[i], space_sin_tbl[i]);
		end
	end

	// Result items are checked before the sample item of the same edge is
	// predicted, since a result can never belong to a sample accepted with it.
	always @(posedge clk or negedge arst_n) begin
		tone_sums_t oldest;
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				window_model[i] = '0;
			end
			write_pos = 0;
			expected_sums.delete();
			mismatch_count <= 0;
			pending_count <= 0;
		end else begin
			if (results.valid === 1'b1 && results.ready === 1'b1) begin
				if (expected_sums.size() == 0) begin
					$error("result item with no expected sums waiting");
					mismatch_count++;
				end else begin
					oldest = expected_sums.pop_front();
					check_field("mark_cos_sum", oldest.mark_cos, results.mark_cos_sum);
					check_field("mark_sin_sum", oldest.mark_sin, results.mark_sin_sum);
					check_field("space_cos_sum", oldest.space_cos, results.space_cos_sum);
					check_field("space_sin_sum", oldest.space_sin, results.space_sin_sum);
				end
			end
			if (samples.valid === 1'b1 && samples.ready === 1'b1) begin
				expected_sums.push_back(correlate_window(samples.sample));
			end
			pending_count <= expected_sums.size();
		end
	end

endmodule

// ----- verif/tb_afsk_tone_correlator_unit.sv -----
`timescale 1ns / 100ps
// ============================================================================
// AFSK tone correlator unit testbench
// Feeds the correlator a directed run of full-scale, alternating and
// near-zero samples, then several hundred random samples, with random
// idling on both channels and two long result stalls that back up the input.
// A checker beside the block predicts and compares every result item.
// ============================================================================

module tb_afsk_tone_correlator_unit;

	localparam int Window        = 8;
	localparam int BitRate       = 1200;
	localparam int RandomItems   = 825;
	localparam int HoldOffCycles = 300;
	localparam int BurstItems    = 40;
	localparam int WatchdogLimit = 3000;
	localparam int DrainCycles   = 4 * (Window + 2);

	logic clk;
	logic arst_n;

	atc_sample_if samples_ch ();
	atc_result_if results_ch ();

	int unsigned mismatch_total;
	int unsigned sums_pending;

	// Flags shared between the sample and result processes, and the burst count.
	bit steady;
	bit hold_off_req;
	int burst_left;

	// Corner samples after the full-scale runs.
	logic signed [15:0] corner_values [9] = '{
		-16'sd1, 16'sd1, 16'sh5555, -16'sh5556, 16'sd0,
		-16'sd32768, 16'sd32767, -16'sd1, 16'sd1
	};

	afsk_tone_correlator_unit #(
		.WINDOW   (Window),
		.BIT_RATE (BitRate)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch)
	);

	atc_correlation_checker #(
		.WINDOW   (Window),
		.BIT_RATE (BitRate)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.samples        (samples_ch),
		.results        (results_ch),
		.mismatch_count (mismatch_total),
		.pending_count  (sums_pending)
	);

	// 10 ns clock.
	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_gap();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			return 0;
		end else if (pick < 85) begin
			return $urandom_range(1, 3);
		end else if (pick < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Random sample: full range, small values near zero, or near full scale.
	function automatic logic signed [15:0] random_sample();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			return 16'($urandom());
		end else if (pick < 75) begin
			return 16'($urandom_range(0, 255) - 128);
		end else if (pick < 90) begin
			return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		end
		return $urandom_range(0, 1) ? 16'(16'h7FF0 + $urandom_range(0, 15))
			: 16'(16'h8000 + $urandom_range(0, 15));
	endfunction

	// Offers one sample item after a gap and waits until it is accepted.
	task automatic send_sample(input logic signed [15:0] value);
		int gap;
		gap = (steady || burst_left > 0) ? 0 : idle_gap();
		if (burst_left > 0) begin
			burst_left--;
		end
		if (gap > 0) begin
			samples_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_ch.valid <= 1'b1;
		samples_ch.sample <= value;
		do begin
			@(posedge clk);
		end while (samples_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	// Sample stimulus and verdict.
	initial begin
		samples_ch.valid = 1'b0;
		samples_ch.sample = '0;
		steady = 1'b0;
		hold_off_req = 1'b0;
		burst_left = 0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: full-scale negative and positive windows, then corners.
		repeat (Window) send_sample(-16'sd32768);
		repeat (Window) send_sample(16'sd32767);
		foreach (corner_values[i]) begin
			send_sample(corner_values[i]);
		end

		// Random samples in segments with and without idling, with two long
		// result stalls while samples keep coming.
		for (int n = 0; n < RandomItems; n++) begin
			if (n % 100 == 0) begin
				steady = ($urandom_range(0, 3) == 0);
			end
			if (n == 250 || n == 600) begin
				hold_off_req = 1'b1;
				burst_left = BurstItems;
			end
			send_sample(random_sample());
		end
		samples_ch.valid <= 1'b0;

		// Drain the block, then keep the clock running for stray items.
		while (sums_pending != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_total == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Result side: random stalls, runs of ready, and long hold-offs on request.
	initial begin
		int stall;
		results_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall = HoldOffCycles;
			end else begin
				stall = steady ? 0 : idle_gap();
			end
			if (stall > 0) begin
				results_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			results_ch.ready <= 1'b1;
			repeat (steady ? 8 : $urandom_range(1, 12)) @(negedge clk);
		end
	end

	// Watchdog on cycles with no item accepted on either channel.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WatchdogLimit) begin
			@(posedge clk);
			if ((samples_ch.valid === 1'b1 && samples_ch.ready === 1'b1)
					|| (results_ch.valid === 1'b1 && results_ch.ready === 1'b1)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("Mismatches found");
		$finish;
	end

endmodule
